### sv/quoted_argument_tokenizer_macros.svh
// ----------------------------------------------------------------------------
// quoted_argument_tokenizer_macros.svh
// Assertion macros for the quoted argument tokenizer.
// ----------------------------------------------------------------------------
`ifndef QUOTED_ARGUMENT_TOKENIZER_MACROS_SVH
`define QUOTED_ARGUMENT_TOKENIZER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define QAT_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qat assertion failed");
// next-cycle implication
`define QAT_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qat assertion failed");
`else
`define QAT_ASSERT_IMPL(name, clk, rst, ante, cons)
`define QAT_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

### sv/qat_pkg.sv
// ----------------------------------------------------------------------------
// qat_pkg
// Types and character codes shared by the quoted argument tokenizer.
// ----------------------------------------------------------------------------
package qat_pkg;

   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0A;

   typedef enum logic [2:0] {
      STATUS_OK             = 3'd0,
      STATUS_BAD_QUOTE      = 3'd1,
      STATUS_UNCLOSED_QUOTE = 3'd2,
      STATUS_DANGLING_ESC   = 3'd3,
      STATUS_OVERFLOW       = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0] char_in;
      logic [7:0] next_char;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic       write_char;
      logic [4:0] arg_index;
      logic [7:0] char_pos;
      logic [7:0] char_value;
      logic       token_end;
      logic [7:0] token_length;
      logic       done_res;
      logic [5:0] closed_count;
      logic [2:0] status;
   } rsp_type;

endpackage

### sv/qat_in_reg.sv
// ----------------------------------------------------------------------------
// qat_in_reg
// Input register: captures one request and holds it until the core takes it.
// ----------------------------------------------------------------------------
module qat_in_reg
   import qat_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   input  logic    advance,
   output logic    held_valid,
   output req_type held_data
);

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;
   logic    load;

   assign req_stall  = valid_ff & ~advance;
   assign load       = req_valid & ~req_stall;
   assign valid_in   = load | (valid_ff & ~advance);
   assign held_valid = valid_ff;
   assign held_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         data_ff <= req_data;
      end
   end

endmodule

### sv/qat_core.sv
// ----------------------------------------------------------------------------
// qat_core
// Tokenizer state and the per-byte update that forms one response.
// ----------------------------------------------------------------------------
module qat_core
   import qat_pkg::*;
#(
   parameter int MAX_ARGS    = 32,
   parameter int MAX_ARG_LEN = 256
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  req_type item,
   output rsp_type result
);

   localparam int POS_W = $clog2(MAX_ARG_LEN);
   localparam int CNT_W = $clog2(MAX_ARGS + 1);
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_ARG_LEN - 1);
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_ARGS);

   logic             in_token_ff, in_token_in;
   logic             in_quotes_ff, in_quotes_in;
   logic             escape_ff, escape_in;
   logic [7:0]       open_quote_ff, open_quote_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             quote_err_ff, quote_err_in;
   logic             overflow_ff, overflow_in;

   logic             do_store;
   logic             do_close;
   logic             close_now;
   logic             wr;
   logic [POS_W-1:0] wr_pos;
   logic             tok_end;
   logic [POS_W-1:0] tok_len;
   status_type       status;
   logic [7:0]       c;

   always_comb begin
      c             = item.char_in;
      in_token_in   = in_token_ff;
      in_quotes_in  = in_quotes_ff;
      escape_in     = escape_ff;
      open_quote_in = open_quote_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      quote_err_in  = quote_err_ff;
      overflow_in   = overflow_ff;
      do_store      = 1'b0;
      do_close      = 1'b0;
      wr            = 1'b0;
      wr_pos        = '0;
      tok_end       = 1'b0;
      tok_len       = '0;
      status        = STATUS_OK;

      if (c == CH_SPACE || c == CH_TAB || c == CH_NL) begin
         if (escape_ff || (in_token_ff && in_quotes_ff)) begin
            do_store = 1'b1;
         end else if (in_token_ff) begin
            do_close = 1'b1;
         end
      end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
         if (escape_ff) begin
            do_store = 1'b1;
         end else if (!in_token_ff) begin
            in_token_in   = 1'b1;
            in_quotes_in  = 1'b1;
            open_quote_in = c;
         end else if (in_quotes_ff) begin
            if (c == open_quote_ff) begin
               do_close = 1'b1;
            end else begin
               do_store = 1'b1;
            end
         end else begin
            quote_err_in = 1'b1;
         end
      end else if (c == CH_BSLASH) begin
         if ((in_quotes_ff && item.next_char != open_quote_ff) || escape_ff) begin
            do_store = 1'b1;
         end else begin
            escape_in = 1'b1;
         end
      end else begin
         do_store = 1'b1;
      end

      if (do_store) begin
         if (count_ff >= CNT_LIMIT || pos_ff >= POS_LIMIT) begin
            overflow_in = 1'b1;
         end else begin
            wr     = 1'b1;
            wr_pos = pos_ff;
            pos_in = pos_ff + POS_W'(1);
         end
         in_token_in = 1'b1;
         escape_in   = 1'b0;
      end

      // close on a separator or matching quote, or an open unquoted token at the end
      close_now = do_close || (item.is_last && in_token_in && !in_quotes_in);
      if (close_now) begin
         if (count_ff >= CNT_LIMIT) begin
            overflow_in = 1'b1;
         end else begin
            tok_end  = 1'b1;
            tok_len  = pos_in;
            count_in = count_ff + CNT_W'(1);
         end
         in_token_in  = 1'b0;
         in_quotes_in = 1'b0;
         pos_in       = '0;
      end

      if (item.is_last) begin
         if (quote_err_in) begin
            status = STATUS_BAD_QUOTE;
         end else if (in_quotes_in) begin
            status = STATUS_UNCLOSED_QUOTE;
         end else if (escape_in) begin
            status = STATUS_DANGLING_ESC;
         end else if (overflow_in) begin
            status = STATUS_OVERFLOW;
         end
      end

      result.write_char   = wr;
      result.arg_index    = 5'(count_ff);
      result.char_pos     = 8'(wr_pos);
      result.char_value   = wr ? c : 8'd0;
      result.token_end    = tok_end;
      result.token_length = 8'(tok_len);
      result.done_res     = item.is_last;
      result.closed_count = 6'(count_in);
      result.status       = status;
   end

   always_ff @(posedge clock) begin
      if (reset || (advance && item.is_last)) begin
         in_token_ff   <= 1'b0;
         in_quotes_ff  <= 1'b0;
         escape_ff     <= 1'b0;
         open_quote_ff <= '0;
         pos_ff        <= '0;
         count_ff      <= '0;
         quote_err_ff  <= 1'b0;
         overflow_ff   <= 1'b0;
      end else if (advance) begin
         in_token_ff   <= in_token_in;
         in_quotes_ff  <= in_quotes_in;
         escape_ff     <= escape_in;
         open_quote_ff <= open_quote_in;
         pos_ff        <= pos_in;
         count_ff      <= count_in;
         quote_err_ff  <= quote_err_in;
         overflow_ff   <= overflow_in;
      end
   end

endmodule

### sv/quoted_argument_tokenizer.sv
// ----------------------------------------------------------------------------
// quoted_argument_tokenizer
// Shell-style splitter of a byte stream into arguments, one byte per request.
// ----------------------------------------------------------------------------
// Takes one request per clock while the response side does not stall, and
// returns exactly one response per request. A request passes an input
// register, then the tokenizer update, then the response register, from which
// its response is offered. The sustained rate is one byte per cycle without
// a response stall, set by the state update in the core. A stall on the
// response side reaches req_stall in the same cycle once both registers hold.
module quoted_argument_tokenizer
   import qat_pkg::*;
#(
   parameter int MAX_ARGS    = 32,
   parameter int MAX_ARG_LEN = 256
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

`include "quoted_argument_tokenizer_macros.svh"

   logic    held_valid;
   req_type held_data;
   logic    advance;
   rsp_type core_rsp;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   assign advance      = held_valid & (~rsp_valid_ff | ~rsp_stall);
   assign rsp_valid_in = advance | (rsp_valid_ff & rsp_stall);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

   qat_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .advance    (advance),
      .held_valid (held_valid),
      .held_data  (held_data)
   );

   qat_core #(
      .MAX_ARGS    (MAX_ARGS),
      .MAX_ARG_LEN (MAX_ARG_LEN)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (held_data),
      .result  (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         rsp_data_ff <= core_rsp;
      end
   end

   `QAT_ASSERT_IMPL(a_status_only_at_end, clock, reset,
      rsp_valid && rsp_data.status != STATUS_OK, rsp_data.done_res)
   `QAT_ASSERT_IMPL(a_idle_char_fields_zero, clock, reset,
      rsp_valid && !rsp_data.write_char,
      rsp_data.char_pos == 8'd0 && rsp_data.char_value == 8'd0)
   `QAT_ASSERT_IMPL(a_close_counts_one, clock, reset,
      rsp_valid && rsp_data.token_end,
      5'(rsp_data.closed_count) == 5'(rsp_data.arg_index + 5'd1))
   `QAT_ASSERT_NEXT(a_core_moves_to_output, clock, reset,
      advance, rsp_valid && rsp_data == $past(core_rsp))

endmodule

### tb/sv/qat_token_event_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// qat_token_event_checker
// Watches both channels of the quoted argument tokenizer. Every accepted
// request runs through a cycle-free model of the tokenizer, and the
// predicted response waits in order until the block returns its own. Each
// returned response is compared field by field against the oldest
// prediction. Mismatch and outstanding counts go back to the top level.
// ----------------------------------------------------------------------------
module qat_token_event_checker
   import qat_pkg::*;
#(
   parameter int MAX_ARGS    = 32,
   parameter int MAX_ARG_LEN = 256
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      mismatch_count,
   output int      events_outstanding
);

   logic       in_arg;
   logic       in_quote;
   logic       escape_armed;
   logic [7:0] open_quote;
   int         arg_pos;
   int         args_closed;
   logic       quote_fault;
   logic       overflow_hit;

   rsp_type    step_event;
   rsp_type    token_event_q[$];
   rsp_type    want;
   int         fail_tally = 0;

   initial begin
      mismatch_count     = 0;
      events_outstanding = 0;
   end

   function automatic void clear_tokenizer_state();
      in_arg       = 1'b0;
      in_quote     = 1'b0;
      escape_armed = 1'b0;
      open_quote   = 8'h00;
      arg_pos      = 0;
      args_closed  = 0;
      quote_fault  = 1'b0;
      overflow_hit = 1'b0;
   endfunction

   function automatic void store_arg_char(input logic [7:0] c);
      if (args_closed >= MAX_ARGS || arg_pos >= MAX_ARG_LEN - 1) begin
         overflow_hit = 1'b1;
      end else begin
         step_event.write_char = 1'b1;
         step_event.char_pos   = arg_pos[7:0];
         step_event.char_value = c;
         arg_pos++;
      end
      in_arg       = 1'b1;
      escape_armed = 1'b0;
   endfunction

   function automatic void close_arg();
      if (args_closed >= MAX_ARGS) begin
         overflow_hit = 1'b1;
      end else begin
         step_event.token_end    = 1'b1;
         step_event.token_length = arg_pos[7:0];
         args_closed++;
      end
      in_arg   = 1'b0;
      in_quote = 1'b0;
      arg_pos  = 0;
   endfunction

   function automatic rsp_type tokenize_byte(input req_type r);
      logic [7:0] c;
      int         idx;
      status_type st;
      c          = r.char_in;
      idx        = args_closed;
      st         = STATUS_OK;
      step_event = '0;
      if (c == CH_SPACE || c == CH_TAB || c == CH_NL) begin
         if (escape_armed || (in_arg && in_quote))
            store_arg_char(c);
         else if (in_arg)
            close_arg();
      end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
         if (escape_armed) begin
            store_arg_char(c);
         end else if (!in_arg) begin
            in_arg     = 1'b1;
            in_quote   = 1'b1;
            open_quote = c;
         end else if (in_quote) begin
            if (c == open_quote)
               close_arg();
            else
               store_arg_char(c);
         end else begin
            quote_fault = 1'b1;
         end
      end else if (c == CH_BSLASH) begin
         if ((in_quote && r.next_char != open_quote) || escape_armed)
            store_arg_char(c);
         else
            escape_armed = 1'b1;
      end else begin
         store_arg_char(c);
      end
      if (r.is_last) begin
         if (in_arg && !in_quote)
            close_arg();
         if (quote_fault)
            st = STATUS_BAD_QUOTE;
         else if (in_quote)
            st = STATUS_UNCLOSED_QUOTE;
         else if (escape_armed)
            st = STATUS_DANGLING_ESC;
         else if (overflow_hit)
            st = STATUS_OVERFLOW;
      end
      step_event.arg_index    = idx[4:0];
      step_event.done_res     = r.is_last;
      step_event.closed_count = args_closed[5:0];
      step_event.status       = st;
      if (r.is_last)
         clear_tokenizer_state();
      return step_event;
   endfunction

   function automatic string describe_event(input rsp_type e);
      return $sformatf("wr=%0d idx=%0d pos=%0d val=%02h end=%0d len=%0d done=%0d cnt=%0d st=%0d",
                       e.write_char, e.arg_index, e.char_pos, e.char_value, e.token_end,
                       e.token_length, e.done_res, e.closed_count, e.status);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_tokenizer_state();
         token_event_q.delete();
      end else begin
         if (req_valid && !req_stall)
            token_event_q.push_back(tokenize_byte(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (token_event_q.size() == 0) begin
               fail_tally++;
               if (fail_tally <= 10)
                  $display("%0t unexpected response: %s", $time, describe_event(rsp_data));
            end else begin
               want = token_event_q.pop_front();
               if (rsp_data.write_char   !== want.write_char   ||
                   rsp_data.arg_index    !== want.arg_index    ||
                   rsp_data.char_pos     !== want.char_pos     ||
                   rsp_data.char_value   !== want.char_value   ||
                   rsp_data.token_end    !== want.token_end    ||
                   rsp_data.token_length !== want.token_length ||
                   rsp_data.done_res     !== want.done_res     ||
                   rsp_data.closed_count !== want.closed_count ||
                   rsp_data.status       !== want.status) begin
                  fail_tally++;
                  if (fail_tally <= 10) begin
                     $display("%0t response mismatch", $time);
                     $display("   expected %s", describe_event(want));
                     $display("   actual   %s", describe_event(rsp_data));
                  end
               end
            end
         end
      end
      mismatch_count     <= fail_tally;
      events_outstanding <= token_event_q.size();
   end

endmodule

### tb/sv/tb_quoted_argument_tokenizer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quoted_argument_tokenizer
// Drives command strings into the quoted argument tokenizer, one byte per
// request with its lookahead and last-byte flag. A short directed set covers
// quoting, escapes, bad and unclosed quotes and byte extremes; random strings
// follow, mostly well-formed with random content, plus long arguments, too
// many arguments, broken endings and noise. Both sides idle at random, and
// the response side holds off once for a long stretch. A separate checker
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_quoted_argument_tokenizer;
   import qat_pkg::*;

   localparam int RANDOM_ITEMS = 500;
   localparam int CYCLE_LIMIT  = 100000;
   localparam int LONG_HOLD    = 400;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int         mismatch_count;
   int         events_outstanding;
   int         cycle_count = 0;
   int         bytes_sent  = 0;
   int         rsp_seen    = 0;
   bit         burst       = 1'b0;
   bit         rsp_quiet   = 1'b0;
   logic [7:0] cmd_bytes[$];

   always #4 clock = ~clock;

   quoted_argument_tokenizer uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   qat_token_event_checker #(
      .MAX_ARGS    (32),
      .MAX_ARG_LEN (256)
   ) event_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data           (req_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_data           (rsp_data),
      .mismatch_count     (mismatch_count),
      .events_outstanding (events_outstanding)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic logic [7:0] plain_byte();
      logic [7:0] c;
      case ($urandom_range(0, 9))
         0: c = 8'($urandom_range(128, 255));
         1: c = 8'($urandom_range(0, 8));
         default: begin
            do c = 8'($urandom_range(33, 126));
            while (c == CH_SQUOTE || c == CH_DQUOTE || c == CH_BSLASH);
         end
      endcase
      return c;
   endfunction

   function automatic logic [7:0] separator_byte();
      case ($urandom_range(0, 3))
         0: return CH_TAB;
         1: return CH_NL;
         default: return CH_SPACE;
      endcase
   endfunction

   function automatic logic [7:0] quoted_byte(input logic [7:0] q);
      case ($urandom_range(0, 11))
         0: return CH_SPACE;
         1: return CH_TAB;
         2: return (q == CH_SQUOTE) ? CH_DQUOTE : CH_SQUOTE;
         3: return CH_BSLASH;
         default: return plain_byte();
      endcase
   endfunction

   function automatic logic [7:0] noise_byte();
      case ($urandom_range(0, 7))
         0: return CH_SQUOTE;
         1: return CH_DQUOTE;
         2: return CH_BSLASH;
         3: return separator_byte();
         4, 5: return 8'($urandom_range(0, 255));
         default: return plain_byte();
      endcase
   endfunction

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++)
         cmd_bytes.push_back(s[i]);
   endtask

   task automatic add_plain(input int n);
      repeat (n) cmd_bytes.push_back(plain_byte());
   endtask

   task automatic add_token();
      logic [7:0] q;
      int         n;
      n = $urandom_range(0, 5);
      case ($urandom_range(0, 3))
         0: add_plain(n + 1);
         1, 2: begin
            q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
            cmd_bytes.push_back(q);
            repeat (n) begin
               if ($urandom_range(0, 5) == 0) begin
                  cmd_bytes.push_back(CH_BSLASH);
                  cmd_bytes.push_back(q);
               end else begin
                  cmd_bytes.push_back(quoted_byte(q));
               end
            end
            cmd_bytes.push_back(q);
         end
         default: begin
            add_plain(n);
            cmd_bytes.push_back(CH_BSLASH);
            cmd_bytes.push_back(8'($urandom_range(0, 255)));
            add_plain($urandom_range(0, 3));
         end
      endcase
   endtask

   task automatic build_command();
      int tokens;
      tokens = $urandom_range(1, 6);
      if ($urandom_range(0, 3) == 0)
         cmd_bytes.push_back(separator_byte());
      for (int t = 0; t < tokens; t++) begin
         if (t > 0 && $urandom_range(0, 5) != 0)
            repeat ($urandom_range(1, 2)) cmd_bytes.push_back(separator_byte());
         add_token();
      end
      case ($urandom_range(0, 9))
         0: cmd_bytes.push_back(CH_BSLASH);
         1: begin
            cmd_bytes.push_back(CH_DQUOTE);
            add_plain(2);
         end
         2: cmd_bytes.push_back(separator_byte());
         default: ;
      endcase
   endtask

   task automatic offer_byte(input req_type r);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock);
      while (req_stall);
      bytes_sent++;
   endtask

   task automatic send_command(input bit garble);
      req_type r;
      burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < cmd_bytes.size(); i++) begin
         r.char_in   = cmd_bytes[i];
         r.is_last   = (i == cmd_bytes.size() - 1);
         r.next_char = r.is_last ? 8'h00 : cmd_bytes[i + 1];
         if (garble && $urandom_range(0, 3) == 0)
            r.next_char = 8'($urandom_range(0, 255));
         offer_byte(r);
      end
      cmd_bytes.delete();
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock);
      while (events_outstanding != 0);
   endtask

   // response side: random stall per response, one long hold-off
   initial begin
      int n;
      do @(posedge clock);
      while (reset);
      forever begin
         if (rsp_seen % 25 == 0)
            rsp_quiet = ($urandom_range(0, 3) == 0);
         if (rsp_seen == 120)
            n = LONG_HOLD;
         else
            n = rsp_quiet ? 0 : $urandom_range(0, 7);
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock);
         while (!rsp_valid);
         rsp_seen++;
      end
   end

   initial begin
      int rand_start;
      int cmd_no;
      int pick;
      bit garble;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      push_text("'x y'z w");
      send_command(1'b0);
      push_text("\"p\\\"\\q");
      send_command(1'b0);
      push_text("\\ a\"b\\");
      send_command(1'b0);
      cmd_bytes.push_back(8'h00);
      cmd_bytes.push_back(CH_TAB);
      cmd_bytes.push_back(8'hFF);
      cmd_bytes.push_back(CH_NL);
      cmd_bytes.push_back(8'h80);
      send_command(1'b0);
      wait_for_drain();

      rand_start = bytes_sent;
      cmd_no     = 0;
      while (bytes_sent - rand_start < RANDOM_ITEMS) begin
         pick   = $urandom_range(0, 99);
         garble = 1'b0;
         if (cmd_no == 0 || pick < 2) begin
            add_plain($urandom_range(250, 270));
            cmd_bytes.push_back(CH_SPACE);
            add_plain(2);
         end else if (cmd_no == 1 || pick < 5) begin
            repeat ($urandom_range(31, 38)) begin
               add_plain($urandom_range(1, 2));
               cmd_bytes.push_back(CH_SPACE);
            end
            add_token();
         end else if (pick < 80) begin
            build_command();
         end else begin
            repeat ($urandom_range(1, 12)) cmd_bytes.push_back(noise_byte());
            garble = 1'b1;
         end
         send_command(garble);
         cmd_no++;
         if (cmd_no == 25)
            wait_for_drain();
      end

      wait_for_drain();
      repeat (16) @(posedge clock);
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
